### sv/square_spiral_zone_coordinate_assert.svh
// Assertion macros used by the square spiral zone coordinate checker.
`ifndef SQUARE_SPIRAL_ZONE_COORDINATE_ASSERT_SVH
`define SQUARE_SPIRAL_ZONE_COORDINATE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SSZC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sszc: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SSZC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sszc: next-cycle check failed");

`endif

### sv/sszc_pkg.sv
// Shared types and constants of the square spiral zone coordinate block.
package sszc_pkg;

  localparam int unsigned CoordW          = 19;
  localparam int unsigned IndexW          = 12;
  localparam int unsigned SizeW           = 12;
  localparam int unsigned LegW            = 7;
  localparam int unsigned FracW           = 4;
  localparam int unsigned MaxIndexDefault = 4095;
  localparam logic [SizeW-1:0] ZoneSizeReset = 12'd56;

  // Walk heading, numbered as the spiral turns counterclockwise downward.
  typedef enum logic [1:0] {
    HEAD_NORTH = 2'd0,
    HEAD_EAST  = 2'd1,
    HEAD_SOUTH = 2'd2,
    HEAD_WEST  = 2'd3
  } heading_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } sszc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
  } sszc_sts_t;

endpackage

### sv/square_spiral_zone_coordinate.sv
// Top level of the square spiral zone coordinate block.
// Each accepted zone index restarts the walk at (zone_size, zone_size) heading
// west and advances one spiral step per clock in the datapath until the step
// count reaches the index, held to MAX_INDEX and to the range of the index
// field. One index is walked at a time; a new index is taken as soon as the
// finished result sits in the output register, even if the output side still
// stalls. The zone size register may be written whenever the block is idle;
// its port is always ready.
module square_spiral_zone_coordinate import sszc_pkg::*; #(
  parameter int unsigned MAX_INDEX = MaxIndexDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [IndexW-1:0]        zone_index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] zone_x_o,
  output logic signed [CoordW-1:0] zone_y_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [SizeW-1:0]         zone_size_i
);

  sszc_cmd_t cmd;
  sszc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sszc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sszc_datapath #(
    .MAX_INDEX (MAX_INDEX)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .zone_index_i (zone_index_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .zone_size_i  (zone_size_i),
    .zone_x_o     (zone_x_o),
    .zone_y_o     (zone_y_o)
  );

endmodule

### sv/sszc_datapath.sv
// Datapath: zone size register, spiral walk registers and result register.
module sszc_datapath import sszc_pkg::*; #(
  parameter int unsigned MAX_INDEX = MaxIndexDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sszc_cmd_t                cmd_i,
  output sszc_sts_t                sts_o,
  input  logic [IndexW-1:0]        zone_index_i,
  input  logic                     cfg_we_i,
  input  logic [SizeW-1:0]         zone_size_i,
  output logic signed [CoordW-1:0] zone_x_o,
  output logic signed [CoordW-1:0] zone_y_o
);

  // Step limit: the index field cannot ask for more than its own range.
  localparam int unsigned IndexMax = (1 << IndexW) - 1;
  localparam int unsigned Limit    = (MAX_INDEX > IndexMax) ? IndexMax : MAX_INDEX;
  localparam int unsigned CntW     = (Limit < 2) ? 1 : $clog2(Limit + 1);
  localparam logic signed [CoordW:0] CoordMax = (CoordW+1)'((1 << (CoordW-1)) - 1);
  localparam logic signed [CoordW:0] CoordMin = -(CoordW+1)'(1 << (CoordW-1));

  logic [SizeW-1:0]         zone_size_q;
  logic signed [CoordW-1:0] walk_x_q, walk_y_q, walk_x_d, walk_y_d;
  heading_e                 heading_q, heading_d;
  logic [LegW-1:0]          leg_len_q, leg_len_d;
  logic [LegW-1:0]          leg_steps_q, leg_steps_d;
  logic [1:0]               legs_q, legs_d;
  logic                     turn_q, turn_d;
  logic [CntW-1:0]          cnt_q, target_q;
  logic [CntW-1:0]          target_d;
  logic signed [CoordW-1:0] zone_x_q, zone_y_q;

  logic signed [CoordW:0]   step_dist;
  logic signed [CoordW:0]   sum;
  logic signed [CoordW-1:0] sat;
  logic                     on_x;
  logic [LegW-1:0]          len_a, steps_n;
  logic [1:0]               legs_a;

  // Configuration register; the user must write it between requests only, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_size_q <= ZoneSizeReset;
    end else if (cfg_we_i) begin
      zone_size_q <= zone_size_i;
    end
  end

  // Step distance is the integer part of the zone size, kept in fixed point.
  assign step_dist = (CoordW+1)'({zone_size_q[SizeW-1:FracW], {FracW{1'b0}}});

  // Requested step count, held to the limit.
  assign target_d = (zone_index_i > IndexW'(Limit)) ? CntW'(Limit) : CntW'(zone_index_i);

  // One spiral step: move along the heading and saturate the moved axis.
  always_comb begin
    on_x = (heading_q == HEAD_EAST) || (heading_q == HEAD_WEST);
    case (heading_q)
      HEAD_NORTH: sum = (CoordW+1)'(walk_y_q) + step_dist;
      HEAD_EAST:  sum = (CoordW+1)'(walk_x_q) + step_dist;
      HEAD_SOUTH: sum = (CoordW+1)'(walk_y_q) - step_dist;
      default:    sum = (CoordW+1)'(walk_x_q) - step_dist;
    endcase
    if (sum > CoordMax) begin
      sat = CoordMax[CoordW-1:0];
    end else if (sum < CoordMin) begin
      sat = CoordMin[CoordW-1:0];
    end else begin
      sat = sum[CoordW-1:0];
    end
    walk_x_d = on_x ? sat : walk_x_q;
    walk_y_d = on_x ? walk_y_q : sat;
  end

  // Leg bookkeeping: length grows after two legs, turn after a leg's last step.
  always_comb begin
    if (legs_q == 2'd2) begin
      len_a  = leg_len_q + LegW'(1);
      legs_a = 2'd0;
    end else begin
      len_a  = leg_len_q;
      legs_a = legs_q;
    end
    leg_len_d = len_a;
    steps_n   = leg_steps_q + LegW'(1);
    if (steps_n == len_a) begin
      leg_steps_d = '0;
      legs_d      = legs_a + 2'd1;
      turn_d      = 1'b1;
    end else begin
      leg_steps_d = steps_n;
      legs_d      = legs_a;
      turn_d      = 1'b0;
    end
    if (turn_q) begin
      case (heading_q)
        HEAD_NORTH: heading_d = HEAD_WEST;
        HEAD_EAST:  heading_d = HEAD_NORTH;
        HEAD_SOUTH: heading_d = HEAD_EAST;
        default:    heading_d = HEAD_SOUTH;
      endcase
    end else begin
      heading_d = heading_q;
    end
  end

  // Walk registers: reloaded on a new request, advanced one step a cycle until the walk is done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q    <= '0;
      walk_y_q    <= '0;
      heading_q   <= HEAD_WEST;
      leg_len_q   <= LegW'(1);
      leg_steps_q <= '0;
      legs_q      <= 2'd1;
      turn_q      <= 1'b1;
      cnt_q       <= '0;
      target_q    <= '0;
    end else if (cmd_i.load) begin
      walk_x_q    <= CoordW'(zone_size_q);
      walk_y_q    <= CoordW'(zone_size_q);
      heading_q   <= HEAD_WEST;
      leg_len_q   <= LegW'(1);
      leg_steps_q <= '0;
      legs_q      <= 2'd1;
      turn_q      <= 1'b1;
      cnt_q       <= '0;
      target_q    <= target_d;
    end else if (cmd_i.step) begin
      walk_x_q    <= walk_x_d;
      walk_y_q    <= walk_y_d;
      heading_q   <= heading_d;
      leg_len_q   <= leg_len_d;
      leg_steps_q <= leg_steps_d;
      legs_q      <= legs_d;
      turn_q      <= turn_d;
      cnt_q       <= cnt_q + CntW'(1);
    end
  end

  assign sts_o.walk_done = (cnt_q == target_q);

  // Result register holds the finished beat while the output side stalls.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      zone_x_q <= walk_x_q;
      zone_y_q <= walk_y_q;
    end
  end

  assign zone_x_o = zone_x_q;
  assign zone_y_o = zone_y_q;

endmodule

### sv/sszc_ctrl.sv
// Controller: request sequencing and output valid tracking.
module sszc_ctrl import sszc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  sszc_sts_t sts_i,
  output sszc_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // State register and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result register is free when empty or when its beat leaves now.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!sts_i.walk_done) begin
          cmd_o.step = 1'b1;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/sszc_checker.sv
// Port-level checker for the square spiral zone coordinate block, with its bind.
`include "square_spiral_zone_coordinate_assert.svh"

module sszc_checker import sszc_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [CoordW-1:0] zone_x_o,
  input logic signed [CoordW-1:0] zone_y_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o
);

  // A stalled result beat keeps its payload.
  `SSZC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(zone_x_o) && $stable(zone_y_o))

  // An accepted index keeps the input side busy for at least the next cycle.
  `SSZC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // A fresh result appears only once the walk is over and the block is idle.
  `SSZC_ASSERT_IMPLIES(a_idle_on_result, $rose(out_valid_o), !in_stall_o)

  // The zone size port never holds off a write.
  `SSZC_ASSERT_IMPLIES(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind square_spiral_zone_coordinate sszc_checker u_sszc_checker (.*);
